/* src/forward_difference_edge_map_defines.svh */
// Assertion macros shared by the edge map RTL.
`ifndef FORWARD_DIFFERENCE_EDGE_MAP_DEFINES_SVH
`define FORWARD_DIFFERENCE_EDGE_MAP_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset.
`define FDEM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define FDEM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FDEM_ASSERT(lbl, clk, rst_n, prop, msg)
`define FDEM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* src/fdem_pkg.sv */
package fdem_pkg;

    localparam int MAX_WIDTH       = 1024;
    localparam int PIXEL_BITS      = 16;
    localparam int HEIGHT_LIMIT    = 4096;
    localparam int COL_BITS        = $clog2(MAX_WIDTH);
    localparam int ROW_BITS        = $clog2(HEIGHT_LIMIT);
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 13;
    localparam int CFG_DATA_BITS   = 13;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int EDGE_BITS       = 17;

    typedef logic [PIXEL_BITS-1:0] t_pixel;
    typedef logic [EDGE_BITS-1:0]  t_edge;
    typedef logic [COL_BITS-1:0]   t_col;
    typedef logic [ROW_BITS-1:0]   t_row;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'b1;

endpackage

/* src/forward_difference_edge_map.sv */
// Forward-difference edge map, |below - here| + |right - here| per pixel.
// A pixel's result is computed when the pixel below it enters the compute stage, a
// last-row result when the pixel to its right does, and each is registered for output.
// Throughput: 1 pixel per cycle unless the output stalls or a pixel owes more than one
// result (last row: up to 2, bottom-right pixel: 3), set by the single output register.
// Reset: synchronous, active low; width and height return to 1024, frame restarts.
`include "forward_difference_edge_map_defines.svh"

module forward_difference_edge_map
    import fdem_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write port
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    // pixel input channel
    input  logic                      i_pixel_valid,
    output logic                      o_pixel_stall,
    input  logic [PIXEL_BITS-1:0]     i_pixel_value,
    // edge output channel
    output logic                      o_edge_valid,
    input  logic                      i_edge_stall,
    output logic [EDGE_BITS-1:0]      o_edge_value,
    output logic                      o_frame_last
);

    // Result slots a held item may still owe, in delivery order.
    localparam int PEND_V = 0;   // vertical result for the pixel above
    localparam int PEND_H = 1;   // horizontal result for the left neighbor
    localparam int PEND_Z = 2;   // closing zero of the frame

    function automatic t_edge abs_diff(input t_pixel a, input t_pixel b);
        t_edge d;
        d = (a > b) ? t_edge'(a - b) : t_edge'(b - a);
        return d;
    endfunction

    // ---------------------------------------------------------------
    // Frame geometry, kept as last column and last row indexes
    // ---------------------------------------------------------------
    t_col r_wlast;
    t_row r_hlast;

    // ---------------------------------------------------------------
    // Input side: position counters and left neighbor
    // ---------------------------------------------------------------
    t_col   r_col;
    t_row   r_row;
    t_pixel r_left;
    t_col   n_col;
    t_row   n_row;
    logic   in_acc;
    logic   col_last;
    logic   row_last;
    t_col   rd_addr;

    // ---------------------------------------------------------------
    // Line store: previous row, one read and one write per cycle
    // ---------------------------------------------------------------
    t_pixel row_store [MAX_WIDTH];
    t_pixel r_rd_data;
    t_pixel r_fwd_data;
    logic   r_fwd_sel;
    t_pixel above_next;

    // ---------------------------------------------------------------
    // Compute stage: one item held; unless the output stalls, results drain one a cycle
    // ---------------------------------------------------------------
    logic       r_s1_valid;
    logic [2:0] r_pend;
    logic       r_s1_has_next;
    t_pixel     r_s1_pixel;
    t_pixel     r_s1_left;
    t_pixel     r_above;

    t_edge      edge_v;
    t_edge      edge_h;
    logic       out_load;
    logic       s1_done;
    logic [2:0] pend_sel;
    t_edge      sel_value;
    logic       sel_last;

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic  r_out_valid;
    t_edge r_out_value;
    logic  r_out_last;

    assign col_last = (r_col == r_wlast);
    assign row_last = (r_row == r_hlast);

    // Fetch the above value for the next pixel: next column, or column 0 on wrap.
    assign rd_addr = col_last ? '0 : t_col'(r_col + 1'b1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_last) begin
            n_col = '0;
            n_row = row_last ? '0 : t_row'(r_row + 1'b1);
        end else begin
            n_col = t_col'(r_col + 1'b1);
        end
    end

    // Drain the lowest pending slot first: vertical, then horizontal, then zero.
    always_comb begin
        pend_sel  = '0;
        sel_value = '0;
        sel_last  = 1'b0;
        priority if (r_pend[PEND_V]) begin
            pend_sel[PEND_V] = 1'b1;
            sel_value        = edge_v;
        end else if (r_pend[PEND_H]) begin
            pend_sel[PEND_H] = 1'b1;
            sel_value        = edge_h;
        end else if (r_pend[PEND_Z]) begin
            pend_sel[PEND_Z] = 1'b1;
            sel_last         = 1'b1;
        end else begin
            pend_sel = '0;
        end
    end

    // Right neighbor of the row above; same-cycle write wins on a one-pixel row.
    assign above_next = r_fwd_sel ? r_fwd_data : r_rd_data;

    assign edge_v = t_edge'(abs_diff(r_s1_pixel, r_above)
                    + (r_s1_has_next ? abs_diff(above_next, r_above) : t_edge'(0)));
    assign edge_h = abs_diff(r_s1_pixel, r_s1_left);

    assign out_load = r_s1_valid && (r_pend != '0) && (!r_out_valid || !i_edge_stall);
    // Item leaves once its last result moves into the output register (or owes none).
    assign s1_done  = r_s1_valid && ((r_pend == '0) || (out_load && (r_pend == pend_sel)));

    assign o_pixel_stall = r_s1_valid && !s1_done;
    assign in_acc        = i_pixel_valid && !o_pixel_stall;

    // Line store: write the new pixel, read ahead for the next one.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            row_store[r_col] <= i_pixel_value;
            r_rd_data        <= row_store[rd_addr];
            r_fwd_data       <= i_pixel_value;
            r_fwd_sel        <= (rd_addr == r_col);
        end
    end

    // Geometry and input counters; a register write restarts the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast <= t_col'(MAX_WIDTH - 1);
            r_hlast <= t_row'(1024 - 1);
            r_col   <= '0;
            r_row   <= '0;
            r_left  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH: begin
                    if (i_cfg_data[WIDTH_REG_BITS-1:0] == '0) begin
                        r_wlast <= '0;
                    end else if (i_cfg_data[WIDTH_REG_BITS-1:0]
                                 > WIDTH_REG_BITS'(MAX_WIDTH)) begin
                        r_wlast <= t_col'(MAX_WIDTH - 1);
                    end else begin
                        r_wlast <= t_col'(i_cfg_data[WIDTH_REG_BITS-1:0] - 1'b1);
                    end
                end
                CFG_IMAGE_HEIGHT: begin
                    if (i_cfg_data[HEIGHT_REG_BITS-1:0] == '0) begin
                        r_hlast <= '0;
                    end else if (i_cfg_data[HEIGHT_REG_BITS-1:0]
                                 > HEIGHT_REG_BITS'(HEIGHT_LIMIT)) begin
                        r_hlast <= t_row'(HEIGHT_LIMIT - 1);
                    end else begin
                        r_hlast <= t_row'(i_cfg_data[HEIGHT_REG_BITS-1:0] - 1'b1);
                    end
                end
                default: begin
                    r_wlast <= r_wlast;
                end
            endcase
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
        end else if (in_acc) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_left <= i_pixel_value;
        end
    end

    // Compute stage control: take an item, drain its results, hand over the above value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_pend     <= '0;
        end else if (in_acc) begin
            r_s1_valid     <= 1'b1;
            r_pend[PEND_V] <= (r_row != '0);
            r_pend[PEND_H] <= row_last && (r_col != '0);
            r_pend[PEND_Z] <= row_last && col_last;
        end else if (s1_done) begin
            r_s1_valid <= 1'b0;
            r_pend     <= '0;
        end else if (out_load) begin
            r_pend <= r_pend & ~pend_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pixel    <= i_pixel_value;
            r_s1_left     <= r_left;
            r_s1_has_next <= !col_last;
        end
        // Advance the above value as the item leaves; reads go with each taken pixel.
        if (s1_done) begin
            r_above <= above_next;
        end
    end

    // Output register: load a result, hold while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_edge_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value <= sel_value;
            r_out_last  <= sel_last;
        end
    end

    assign o_edge_valid = r_out_valid;
    assign o_edge_value = r_out_value;
    assign o_frame_last = r_out_last;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `FDEM_ASSERT(a_col_in_frame, i_clk, i_rst_n, (r_col <= r_wlast), "column past row end")
    `FDEM_ASSERT(a_row_in_frame, i_clk, i_rst_n, (r_row <= r_hlast), "row past frame end")
    `FDEM_ASSERT(a_last_is_zero, i_clk, i_rst_n,
                 (o_edge_valid && o_frame_last |-> o_edge_value == '0),
                 "frame end result not zero")
    `FDEM_ASSERT(a_take_fills_stage, i_clk, i_rst_n, (in_acc |=> r_s1_valid),
                 "taken item lost")
    `FDEM_ASSERT_ALWAYS(a_pend_needs_item, i_clk, (!r_s1_valid |-> r_pend == '0),
                        "results owed with no item held")

endmodule
